FILE: hdl/pdc_pkg.sv
`timescale 1ns / 1ps

package pdc_pkg;

    // Block dimensions
    localparam int SAMPLES_PER_PERIOD = 1000;
    localparam int CAPTURE_POINTS     = 200;
    localparam int DECIMATION         = 10;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 16;
    localparam int POS_W    = 10;
    localparam int INTEG_W  = 24;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int DECIM_W  = 4;
    localparam int POINT_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reference position limits, one bit wider to match the widened position compare
    localparam logic [POS_W:0] POS_LIMIT = (POS_W + 1)'(SAMPLES_PER_PERIOD);
    localparam logic [POS_W:0] POS_HALF  = (POS_W + 1)'(SAMPLES_PER_PERIOD / 2);
    localparam logic [DECIM_W-1:0] DECIM_LIMIT = DECIM_W'(DECIMATION);
    localparam logic [POINT_W-1:0] POINT_LIMIT = POINT_W'(CAPTURE_POINTS);

    // Integrator saturation bounds
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Output scaling in Q.8: 50 and 100 percent
    localparam int HALF_SCALE_Q8 = 12800;
    localparam int FULL_SCALE_Q8 = 25600;
    localparam int PCT_DIV       = FULL_SCALE_Q8 / 256;
    localparam int RECIP_SHIFT   = 30;
    localparam int RECIP_W       = 24;
    localparam logic [RECIP_W-1:0] RECIP_PCT = RECIP_W'((64'd1 << RECIP_SHIFT) / PCT_DIV);

    // Config reset values
    localparam logic [SAMPLE_W-1:0] REF_HIGH_RST = 10'd800;
    localparam logic [SAMPLE_W-1:0] REF_LOW_RST  = 10'd200;
    localparam logic [DUTY_W-1:0]   PWM_TOP_RST  = 16'd3999;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN  = 3'd0,
        CFG_KI_GAIN  = 3'd1,
        CFG_REF_HIGH = 3'd2,
        CFG_REF_LOW  = 3'd3,
        CFG_PWM_TOP  = 3'd4
    } cfg_index_t;

    // One classified sample, handed from front to back end
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic                      cap_valid;
        logic [POINT_W-1:0]        cap_index;
        logic [SAMPLE_W-1:0]       cap_measured;
        logic [SAMPLE_W-1:0]       cap_reference;
        logic                      cap_done;
    } pdc_job_t;

endpackage

FILE: hdl/pdc_if.sv
`timescale 1ns / 1ps

interface pdc_sample_if;
    import pdc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] measured;
    logic                start_capture;

    modport source (output valid, output measured, output start_capture, input ready);
    modport sink   (input valid, input measured, input start_capture, output ready);
endinterface

interface pdc_result_if;
    import pdc_pkg::*;

    logic                valid;
    logic                ready;
    logic [DUTY_W-1:0]   duty;
    logic                capture_valid;
    logic [POINT_W-1:0]  capture_index;
    logic [SAMPLE_W-1:0] capture_measured;
    logic [SAMPLE_W-1:0] capture_reference;
    logic                capture_done;

    modport source (output valid, output duty, output capture_valid, output capture_index,
                    output capture_measured, output capture_reference,
                    output capture_done, input ready);
    modport sink   (input valid, input duty, input capture_valid, input capture_index,
                    input capture_measured, input capture_reference,
                    input capture_done, output ready);
endinterface

FILE: hdl/pdc_front.sv
`timescale 1ns / 1ps

module pdc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    pdc_sample_if.sink                          sample_ch,
    input  logic [pdc_pkg::SAMPLE_W-1:0]        ref_high,
    input  logic [pdc_pkg::SAMPLE_W-1:0]        ref_low,
    input  logic                                full,
    output logic                                push,
    output pdc_pkg::pdc_job_t                   job
);
    import pdc_pkg::*;

    logic [POS_W-1:0]          pos_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic                      capturing_reg;
    logic [DECIM_W-1:0]        decim_reg;
    logic [POINT_W-1:0]        point_reg;

    logic [POS_W-1:0]          pos_cur;
    logic [POS_W:0]            pos_inc;
    logic [POS_W-1:0]          pos_next;
    logic [SAMPLE_W-1:0]       reference;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ_base;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_next;
    logic                      start;
    logic [DECIM_W-1:0]        decim_base;
    logic [DECIM_W-1:0]        decim_inc;
    logic [DECIM_W-1:0]        decim_next;
    logic [POINT_W-1:0]        point_base;
    logic [POINT_W-1:0]        point_next;
    logic                      capturing_next;
    logic                      cap_valid;
    logic                      cap_done;
    logic [POINT_W-1:0]        cap_index;

    assign sample_ch.ready = ~full;
    assign push            = sample_ch.valid & ~full;
    assign start           = sample_ch.start_capture;

    always_comb
    begin
        // position wraps before use and after increment
        pos_cur   = ({1'b0, pos_reg} >= POS_LIMIT) ? '0 : pos_reg;
        reference = ({1'b0, pos_cur} < POS_HALF) ? ref_high : ref_low;
        pos_inc   = {1'b0, pos_cur} + 1'b1;
        pos_next  = (pos_inc >= POS_LIMIT) ? '0 : pos_inc[POS_W-1:0];

        // error fits 11 bits signed
        err = $signed({1'b0, reference} - {1'b0, sample_ch.measured});

        integ_base = start ? '0 : integ_reg;
        integ_sum  = {integ_base[INTEG_W-1], integ_base}
                   + {{(INTEG_W + 1 - ERR_W){err[ERR_W-1]}}, err};
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
            integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        else
            integ_next = integ_sum[INTEG_W-1:0];

        decim_base     = start ? '0 : decim_reg;
        point_base     = start ? '0 : point_reg;
        decim_inc      = decim_base + 1'b1;
        decim_next     = decim_reg;
        point_next     = point_reg;
        capturing_next = capturing_reg;
        cap_valid      = 1'b0;
        cap_done       = 1'b0;
        cap_index      = '0;
        if (start || capturing_reg)
        begin
            capturing_next = 1'b1;
            decim_next     = decim_inc;
            point_next     = point_base;
            if (decim_inc >= DECIM_LIMIT)
            begin
                decim_next = '0;
                cap_valid  = 1'b1;
                cap_index  = point_base;
                point_next = point_base + 1'b1;
            end
            if (point_next >= POINT_LIMIT)
            begin
                point_next     = '0;
                capturing_next = 1'b0;
                cap_done       = 1'b1;
            end
        end
    end

    always_comb
    begin
        job.err           = err;
        job.integ         = integ_next;
        job.cap_valid     = cap_valid;
        job.cap_index     = cap_index;
        job.cap_measured  = cap_valid ? sample_ch.measured : '0;
        job.cap_reference = cap_valid ? reference : '0;
        job.cap_done      = cap_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            integ_reg     <= '0;
            capturing_reg <= 1'b0;
            decim_reg     <= '0;
            point_reg     <= '0;
        end
        else if (push)
        begin
            pos_reg       <= pos_next;
            integ_reg     <= integ_next;
            capturing_reg <= capturing_next;
            decim_reg     <= decim_next;
            point_reg     <= point_next;
        end
    end

endmodule

FILE: hdl/pdc_queue.sv
`timescale 1ns / 1ps

module pdc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pdc_pkg::pdc_job_t push_data,
    output logic              full,
    input  logic              pop,
    output pdc_pkg::pdc_job_t pop_data,
    output logic              empty
);
    import pdc_pkg::*;

    pdc_job_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: hdl/pdc_back.sv
`timescale 1ns / 1ps

module pdc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [pdc_pkg::GAIN_W-1:0]  kp_gain,
    input  logic signed [pdc_pkg::GAIN_W-1:0]  ki_gain,
    input  logic [pdc_pkg::DUTY_W-1:0]         pwm_top,
    input  logic                               empty,
    input  pdc_pkg::pdc_job_t                  pop_data,
    output logic                               pop,
    pdc_result_if.source                       result_ch
);
    import pdc_pkg::*;

    localparam int PROP_W = GAIN_W + ERR_W;
    localparam int INTP_W = GAIN_W + INTEG_W;
    localparam int U_W    = INTP_W + 1;
    localparam int V_W    = 15;
    localparam int PROD_W = V_W + DUTY_W;
    localparam int Q_W    = PROD_W - 8;
    localparam int EP_W   = Q_W + RECIP_W;
    localparam int EST_W  = EP_W - RECIP_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_RECIP,
        ST_CORR
    } state_t;

    state_t                   state_reg;
    pdc_job_t                 job_reg;
    logic signed [PROP_W-1:0] prop_reg;
    logic signed [INTP_W-1:0] intp_reg;
    logic [V_W-1:0]           v_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [Q_W-1:0]           q_reg;
    logic [EST_W-1:0]         est_reg;
    logic                     out_valid_reg;
    logic [DUTY_W-1:0]        duty_reg;
    pdc_job_t                 out_job_reg;

    logic signed [U_W-1:0]    u_sum;
    logic signed [U_W:0]      v_raw;
    logic [V_W-1:0]           v_next;
    logic [PROD_W-1:0]        prod_next;
    logic [EP_W-1:0]          est_prod;
    logic [Q_W:0]             est_x;
    logic [Q_W:0]             rem;
    logic [DUTY_W-1:0]        duty_next;

    assign pop = (state_reg == ST_IDLE) & ~empty;

    always_comb
    begin
        u_sum = {{(U_W - PROP_W){prop_reg[PROP_W-1]}}, prop_reg}
              + {intp_reg[INTP_W-1], intp_reg};
        v_raw = {u_sum[U_W-1], u_sum} + (U_W + 1)'(HALF_SCALE_Q8);
        if (v_raw[U_W])
            v_next = '0;
        else if (v_raw[U_W-1:0] > U_W'(FULL_SCALE_Q8))
            v_next = V_W'(FULL_SCALE_Q8);
        else
            v_next = v_raw[V_W-1:0];

        prod_next = {{DUTY_W{1'b0}}, v_reg} * {{V_W{1'b0}}, pwm_top};

        // quotient by 100 via reciprocal, at most one short
        est_prod = {{RECIP_W{1'b0}}, prod_reg[PROD_W-1:8]} * {{Q_W{1'b0}}, RECIP_PCT};

        est_x     = {{(Q_W + 1 - EST_W){1'b0}}, est_reg} * (Q_W + 1)'(PCT_DIV);
        rem       = {1'b0, q_reg} - est_x;
        duty_next = (rem >= (Q_W + 1)'(PCT_DIV)) ? DUTY_W'(est_reg + 1'b1)
                                                 : est_reg[DUTY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            prop_reg      <= '0;
            intp_reg      <= '0;
            v_reg         <= '0;
            prod_reg      <= '0;
            q_reg         <= '0;
            est_reg       <= '0;
            out_valid_reg <= 1'b0;
            duty_reg      <= '0;
            out_job_reg   <= '0;
        end
        else
        begin
            // ST_CORR owns the flag in its own cycle
            if (out_valid_reg && result_ch.ready && state_reg != ST_CORR)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        job_reg   <= pop_data;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prop_reg  <= kp_gain * job_reg.err;
                    intp_reg  <= ki_gain * job_reg.integ;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    v_reg     <= v_next;
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_RECIP;
                end
                ST_RECIP:
                begin
                    q_reg     <= prod_reg[PROD_W-1:8];
                    est_reg   <= est_prod[EP_W-1:RECIP_SHIFT];
                    state_reg <= ST_CORR;
                end
                ST_CORR:
                begin
                    if (!out_valid_reg || result_ch.ready)
                    begin
                        duty_reg      <= duty_next;
                        out_job_reg   <= job_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_ch.valid             = out_valid_reg;
    assign result_ch.duty              = duty_reg;
    assign result_ch.capture_valid     = out_job_reg.cap_valid;
    assign result_ch.capture_index     = out_job_reg.cap_index;
    assign result_ch.capture_measured  = out_job_reg.cap_measured;
    assign result_ch.capture_reference = out_job_reg.cap_reference;
    assign result_ch.capture_done      = out_job_reg.cap_done;

endmodule

FILE: hdl/pi_duty_controller_with_capture.sv
`timescale 1ns / 1ps
// Path: an accepted sample request passes through the queue and the back-end states
//   ST_IDLE, ST_MUL, ST_SUM, ST_SCALE, ST_RECIP and ST_CORR into the output register.
// Pacing: the back end takes no new request until its sequential multiply, clamp,
//   scale and divide-by-100 steps are done; a 2-deep queue takes requests ahead.
// Reset: rst_n asynchronous, active low; clears all controller state and loads
//   the config registers with their defaults (ref 800/200, pwm_top 3999, gains 0).

module pi_duty_controller_with_capture (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]    cfg_data,
    pdc_sample_if.sink                        sample_ch,
    pdc_result_if.source                      result_ch
);
    import pdc_pkg::*;

    // Config registers; write only while the block is idle (the block itself does not enforce it).
    logic signed [GAIN_W-1:0] kp_gain_reg;
    logic signed [GAIN_W-1:0] ki_gain_reg;
    logic [SAMPLE_W-1:0]      ref_high_reg;
    logic [SAMPLE_W-1:0]      ref_low_reg;
    logic [DUTY_W-1:0]        pwm_top_reg;

    // Front end -> queue -> back end
    logic     push;
    logic     full;
    logic     pop;
    logic     empty;
    pdc_job_t push_job;
    pdc_job_t pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg  <= '0;
            ki_gain_reg  <= '0;
            ref_high_reg <= REF_HIGH_RST;
            ref_low_reg  <= REF_LOW_RST;
            pwm_top_reg  <= PWM_TOP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KP_GAIN:  kp_gain_reg  <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_KI_GAIN:  ki_gain_reg  <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_REF_HIGH: ref_high_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_REF_LOW:  ref_low_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_PWM_TOP:  pwm_top_reg  <= cfg_data[DUTY_W-1:0];
                default:      ; // unmapped index: dropped
            endcase
        end
    end

    // Front end: square-wave reference, error, saturating integrator and
    // capture bookkeeping, all settled in the cycle the request is accepted.
    pdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .ref_high  (ref_high_reg),
        .ref_low   (ref_low_reg),
        .full      (full),
        .push      (push),
        .job       (push_job)
    );

    // Short queue so the front end keeps taking requests while the back end
    // works or the output is stalled.
    pdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (empty)
    );

    // Back end: kp*err + ki*integ, offset by 50 percent, clamp to 0..100 percent,
    // scale by pwm_top and divide by 25600 (shift by 8, then reciprocal of 100
    // with one correction step). Result held in an output register.
    pdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .kp_gain   (kp_gain_reg),
        .ki_gain   (ki_gain_reg),
        .pwm_top   (pwm_top_reg),
        .empty     (empty),
        .pop_data  (pop_job),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule

FILE: hdl/pdc_checker.sv
`timescale 1ns / 1ps

module pdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [15:0] duty,
    input logic        capture_valid,
    input logic [7:0]  capture_index,
    input logic [9:0]  capture_measured,
    input logic [9:0]  capture_reference,
    input logic        capture_done
);
    import pdc_pkg::*;

    // stalled result holds its duty, capture index and done flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(duty)
            && $stable(capture_index) && $stable(capture_done))
        else $error("stalled result changed");

    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !capture_valid |-> capture_index == '0
            && capture_measured == '0 && capture_reference == '0)
        else $error("capture fields not blank without capture point");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && capture_done |-> capture_valid
            && capture_index == 8'(CAPTURE_POINTS - 1))
        else $error("capture done on wrong point");

    a_rst: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid out of reset");

endmodule

bind pi_duty_controller_with_capture pdc_checker u_pdc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .result_valid      (result_ch.valid),
    .result_ready      (result_ch.ready),
    .duty              (result_ch.duty),
    .capture_valid     (result_ch.capture_valid),
    .capture_index     (result_ch.capture_index),
    .capture_measured  (result_ch.capture_measured),
    .capture_reference (result_ch.capture_reference),
    .capture_done      (result_ch.capture_done)
);
